[hw/rtl/hrbp_pkg.sv]
// Shared types, constants and helper functions for the HTTP request byte parser.
// No dependencies; imported by every module of the block.
package hrbp_pkg;

	// default width of the Content-Length accumulator
	localparam int LENGTH_BITS_DEF = 32;
	// width of the body length field in the result beat
	localparam int LEN_OUT_W = 32;

	// header name that carries the body length
	localparam int NAME_LEN   = 14;
	localparam int NAME_POS_W = 4;
	localparam logic [NAME_POS_W-1:0] NAME_POS_MAX = '1;

	// characters of interest
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// part of the request the parser is in
	typedef enum logic [3:0] {
		SEC_METHOD  = 4'd0,
		SEC_PATH    = 4'd1,
		SEC_QUERY   = 4'd2,
		SEC_VERSION = 4'd3,
		SEC_HNAME   = 4'd4,
		SEC_HVALUE  = 4'd5,
		SEC_EMPTY   = 4'd6,
		SEC_BODY    = 4'd7,
		SEC_DONE    = 4'd8
	} sec_t;

	// tag carried with every result beat
	typedef enum logic [2:0] {
		TAG_DROP   = 3'd0,
		TAG_METHOD = 3'd1,
		TAG_PATH   = 3'd2,
		TAG_QUERY  = 3'd3,
		TAG_HNAME  = 3'd4,
		TAG_HVALUE = 3'd5,
		TAG_BODY   = 3'd6
	} tag_t;

	// progress through a header value read as a number
	typedef enum logic [1:0] {
		VP_START = 2'd0,
		VP_POS   = 2'd1,
		VP_NEG   = 2'd2,
		VP_STOP  = 2'd3
	} vphase_t;

	// one result beat
	typedef struct packed {
		tag_t                 tag;
		logic [7:0]           data;
		logic                 done;
		logic [LEN_OUT_W-1:0] body_length;
	} result_t;

	// ASCII upper case to lower case
	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_UC_A && c <= CH_UC_Z)
			r = c + CASE_OFS;
		return r;
	endfunction

	// "content-length", one character per position
	function automatic logic [7:0] cl_char(input logic [NAME_POS_W-1:0] pos);
		logic [7:0] r;
		r = 8'h00;
		unique case (pos)
			4'd0:    r = 8'h63; // c
			4'd1:    r = 8'h6F; // o
			4'd2:    r = 8'h6E; // n
			4'd3:    r = 8'h74; // t
			4'd4:    r = 8'h65; // e
			4'd5:    r = 8'h6E; // n
			4'd6:    r = 8'h74; // t
			4'd7:    r = 8'h2D; // -
			4'd8:    r = 8'h6C; // l
			4'd9:    r = 8'h65; // e
			4'd10:   r = 8'h6E; // n
			4'd11:   r = 8'h67; // g
			4'd12:   r = 8'h74; // t
			4'd13:   r = 8'h68; // h
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/hrbp_value_reader.sv]
// Header value reader: one character step of the decimal length decoder.
// Depends on hrbp_pkg.
module hrbp_value_reader #(
	parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
	input  logic [7:0]             c,
	input  hrbp_pkg::vphase_t      phase,
	input  logic [LENGTH_BITS-1:0] accum,
	output hrbp_pkg::vphase_t      phase_next,
	output logic [LENGTH_BITS-1:0] accum_next
);
	import hrbp_pkg::*;

	localparam int PW = LENGTH_BITS + 4;

	logic                 is_digit;
	logic [3:0]           digit;
	logic [PW-1:0]        prod;
	logic                 ovf;
	logic [LENGTH_BITS-1:0] acc_pos;
	logic [LENGTH_BITS-1:0] acc_neg;

	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign digit    = c[3:0];

	// accum*10 + d; anything above the low LENGTH_BITS bits is overflow
	assign prod = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + PW'(digit);
	assign ovf  = prod[PW-1:LENGTH_BITS] != 4'b0;

	assign acc_pos = ovf ? '1 : prod[LENGTH_BITS-1:0];
	// negative value: any nonzero digit saturates
	assign acc_neg = (digit != 4'd0) ? '1 : accum;

	// phase and accumulator update
	always_comb begin
		phase_next = phase;
		accum_next = accum;
		unique case (phase)
			VP_START: begin
				if (c == CH_HT || c == CH_VT || c == CH_FF) begin
					phase_next = VP_START;
				end else if (c == CH_PLUS) begin
					phase_next = VP_POS;
				end else if (c == CH_MINUS) begin
					phase_next = VP_NEG;
				end else if (is_digit) begin
					phase_next = VP_POS;
					accum_next = acc_pos;
				end else begin
					phase_next = VP_STOP;
				end
			end
			VP_POS: begin
				if (is_digit)
					accum_next = acc_pos;
				else
					phase_next = VP_STOP;
			end
			VP_NEG: begin
				if (is_digit)
					accum_next = acc_neg;
				else
					phase_next = VP_STOP;
			end
			default: begin
				phase_next = VP_STOP;
			end
		endcase
	end

endmodule

[hw/rtl/hrbp_parser.sv]
// Parser state and section sequencer; turns one byte into one result per step.
// Depends on hrbp_pkg and hrbp_value_reader.
module hrbp_parser #(
	parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        c,
	input  logic              first,
	output hrbp_pkg::result_t res
);
	import hrbp_pkg::*;

	// state registers
	sec_t                    sec_q;
	logic [NAME_POS_W-1:0]   pos_q;
	logic                    match_q;
	logic [LENGTH_BITS-1:0]  acc_q;
	vphase_t                 phase_q;
	logic [LENGTH_BITS-1:0]  plen_q;
	logic [LENGTH_BITS-1:0]  bleft_q;

	// state as seen by this byte (restart applied)
	sec_t                    sec_cur;
	logic [NAME_POS_W-1:0]   pos_cur;
	logic                    match_cur;
	logic [LENGTH_BITS-1:0]  acc_cur;
	vphase_t                 phase_cur;
	logic [LENGTH_BITS-1:0]  plen_cur;
	logic [LENGTH_BITS-1:0]  bleft_cur;

	sec_t                    sec_d;
	logic [NAME_POS_W-1:0]   pos_d;
	logic                    match_d;
	logic [LENGTH_BITS-1:0]  acc_d;
	vphase_t                 phase_d;
	logic [LENGTH_BITS-1:0]  plen_d;
	logic [LENGTH_BITS-1:0]  bleft_d;

	logic [7:0]              c_low;
	logic                    name_eq;
	logic                    match_fed;
	logic [NAME_POS_W-1:0]   pos_fed;
	logic                    first_eq;
	logic                    cl_hit;
	logic [LENGTH_BITS-1:0]  bleft_dec;
	vphase_t                 vr_phase;
	logic [LENGTH_BITS-1:0]  vr_acc;
	tag_t                    tag;
	logic                    done;

	// restart on the first byte of a connection
	assign sec_cur   = first ? SEC_METHOD : sec_q;
	assign pos_cur   = first ? '0 : pos_q;
	assign match_cur = first ? 1'b1 : match_q;
	assign acc_cur   = first ? '0 : acc_q;
	assign phase_cur = first ? VP_START : phase_q;
	assign plen_cur  = first ? '0 : plen_q;
	assign bleft_cur = first ? '0 : bleft_q;

	// header name compare, case-insensitive
	assign c_low     = to_lower(c);
	assign name_eq   = c_low == cl_char(pos_cur);
	assign match_fed = match_cur && (pos_cur < NAME_POS_W'(NAME_LEN)) && name_eq;
	assign pos_fed   = (pos_cur == NAME_POS_MAX) ? pos_cur : pos_cur + 1'b1;
	// first name character of a fresh header line
	assign first_eq  = c_low == cl_char('0);
	assign cl_hit    = match_cur && (pos_cur == NAME_POS_W'(NAME_LEN));

	assign bleft_dec = (bleft_cur != '0) ? bleft_cur - 1'b1 : bleft_cur;

	hrbp_value_reader #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_value (
		.c          (c),
		.phase      (phase_cur),
		.accum      (acc_cur),
		.phase_next (vr_phase),
		.accum_next (vr_acc)
	);

	// next section
	always_comb begin
		sec_d = sec_cur;
		unique case (sec_cur)
			SEC_METHOD: begin
				if (c == CH_SPACE)
					sec_d = SEC_PATH;
			end
			SEC_PATH: begin
				if (c == CH_SPACE)
					sec_d = SEC_VERSION;
				else if (c == CH_QMARK)
					sec_d = SEC_QUERY;
			end
			SEC_QUERY: begin
				if (c == CH_SPACE)
					sec_d = SEC_VERSION;
			end
			SEC_VERSION: begin
				if (c == CH_LF)
					sec_d = SEC_EMPTY;
			end
			SEC_HNAME: begin
				if (c == CH_COLON)
					sec_d = SEC_HVALUE;
			end
			SEC_HVALUE: begin
				if (c == CH_LF)
					sec_d = SEC_EMPTY;
			end
			SEC_EMPTY: begin
				if (c == CH_LF)
					sec_d = (plen_cur == '0) ? SEC_DONE : SEC_BODY;
				else if (c != CH_CR)
					sec_d = SEC_HNAME;
			end
			SEC_BODY: begin
				if (bleft_dec == '0)
					sec_d = SEC_DONE;
			end
			default: begin
				sec_d = SEC_DONE;
			end
		endcase
	end

	// tag, completion and datapath updates
	always_comb begin
		tag     = TAG_DROP;
		done    = 1'b0;
		pos_d   = pos_cur;
		match_d = match_cur;
		acc_d   = acc_cur;
		phase_d = phase_cur;
		plen_d  = plen_cur;
		bleft_d = bleft_cur;
		unique case (sec_cur)
			SEC_METHOD: begin
				if (c != CH_SPACE)
					tag = TAG_METHOD;
			end
			SEC_PATH: begin
				if (c != CH_SPACE && c != CH_QMARK)
					tag = TAG_PATH;
			end
			SEC_QUERY: begin
				if (c != CH_SPACE)
					tag = TAG_QUERY;
			end
			SEC_VERSION: begin
				tag = TAG_DROP;
			end
			SEC_HNAME: begin
				if (c != CH_SPACE && c != CH_COLON) begin
					tag     = TAG_HNAME;
					match_d = match_fed;
					pos_d   = pos_fed;
				end
			end
			SEC_HVALUE: begin
				if (c == CH_LF) begin
					if (cl_hit)
						plen_d = acc_cur;
				end else if (c != CH_CR && c != CH_SPACE) begin
					tag     = TAG_HVALUE;
					phase_d = vr_phase;
					acc_d   = vr_acc;
				end
			end
			SEC_EMPTY: begin
				if (c == CH_LF) begin
					if (plen_cur == '0)
						done = 1'b1;
					else
						bleft_d = plen_cur;
				end else if (c != CH_CR) begin
					// new header line: restart name and value tracking
					tag     = TAG_HNAME;
					match_d = first_eq;
					pos_d   = NAME_POS_W'(1);
					acc_d   = '0;
					phase_d = VP_START;
				end
			end
			SEC_BODY: begin
				tag     = TAG_BODY;
				bleft_d = bleft_dec;
				if (bleft_dec == '0)
					done = 1'b1;
			end
			default: begin
				tag = TAG_DROP;
			end
		endcase
	end

	assign res.tag         = tag;
	assign res.data        = c;
	assign res.done        = done;
	assign res.body_length = done ? LEN_OUT_W'(plen_cur) : '0;

	// state update, once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= SEC_METHOD;
			pos_q   <= '0;
			match_q <= 1'b1;
			acc_q   <= '0;
			phase_q <= VP_START;
			plen_q  <= '0;
			bleft_q <= '0;
		end else if (step) begin
			sec_q   <= sec_d;
			pos_q   <= pos_d;
			match_q <= match_d;
			acc_q   <= acc_d;
			phase_q <= phase_d;
			plen_q  <= plen_d;
			bleft_q <= bleft_d;
		end
	end

endmodule

[hw/rtl/http_request_byte_parser_top.sv]
// Top level of the HTTP request byte parser: input register, parser, result register.
// Depends on hrbp_pkg and hrbp_parser.
//
//  channel | dir | tdata                        | tuser          | tlast
//  s_      | in  | [7:0] data_byte              | first_of_req.  | -
//  m_      | out | [7:0] out_byte, [39:8] len   | [2:0] field_tag| request_done
//
// One beat per cycle while m_tready is high; input register, then result register.
// The byte's state update is a single pass of section logic plus one
// multiply-by-ten add in the value reader.
// Reset puts the parser in the method section with all counters at zero.
// With m_tready low the result register holds and one more beat waits in the
// input register; s_tready drops only when both are full and the sink stalls.
module http_request_byte_parser_top #(
	parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] first_of_request
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [7:0] out_byte, [39:8] body_length
	output logic [2:0]  m_tuser,  // [2:0] field_tag
	output logic        m_tlast   // request_done
);
	import hrbp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       advance;
	logic       out_valid_q;
	result_t    res;
	result_t    res_q;

	// a beat moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	hrbp_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.c      (data_s1),
		.first  (first_s1),
		.res    (res)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.body_length, res_q.data};
	assign m_tuser  = res_q.tag;
	assign m_tlast  = res_q.done;

	// completion is only ever flagged on a body byte or a dropped line end
	a_done_tag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tuser == TAG_DROP || m_tuser == TAG_BODY))
		else $error("request_done with unexpected tag");

	// the length field is zero unless the beat completes the request
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[39:8] == '0)
		else $error("body_length nonzero without request_done");

	// completion on the header end means a zero-length body
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tuser == TAG_DROP |-> m_tdata[39:8] == '0)
		else $error("header-end completion with nonzero length");

	// a waiting beat is not lost while the sink stalls
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |=> valid_s1)
		else $error("input beat dropped during stall");

endmodule
